/* rtl/ysf_pkg.sv */
package ysf_pkg;

   localparam int LONG_BLOCK_BYTES  = 1024;
   localparam int SHORT_BLOCK_BYTES = 128;
   localparam int LONG_AW  = $clog2(LONG_BLOCK_BYTES);
   localparam int SHORT_AW = $clog2(SHORT_BLOCK_BYTES);

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_HEADER = 3'd1;
   localparam logic [2:0] OP_FILE   = 3'd2;
   localparam logic [2:0] OP_RX     = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;
   localparam logic [2:0] OP_SLOT   = 3'd5;

   localparam logic [1:0] CSR_FILE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WAIT_START  = 2'd1;
   localparam logic [1:0] CSR_WAIT_ACK    = 2'd2;
   localparam logic [1:0] CSR_WAIT_CLOSE  = 2'd3;

   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [7:0]  CH_SOH     = 8'h01;
   localparam logic [7:0]  CH_STX     = 8'h02;
   localparam logic [7:0]  CH_EOT     = 8'h04;
   localparam logic [7:0]  CH_ACK     = 8'h06;
   localparam logic [7:0]  CH_NAK     = 8'h15;
   localparam logic [7:0]  CH_PAD     = 8'h1A;
   localparam logic [7:0]  CH_C       = 8'h43;
   localparam logic [15:0] WAIT_START_RESET = 16'd5000;
   localparam logic [15:0] WAIT_ACK_RESET   = 16'd3000;
   localparam logic [15:0] WAIT_CLOSE_RESET = 16'd1000;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_BUSY   = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;
   localparam logic [1:0] ST_FAILED = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE, PH_WAIT_START, PH_SEND_HDR, PH_WAIT_HDR_ACK, PH_FILL, PH_SEND_DATA,
      PH_WAIT_DATA_ACK, PH_SEND_EOT, PH_WAIT_EOT_ACK, PH_SEND_CLOSE,
      PH_WAIT_CLOSE_ACK, PH_DONE, PH_FAILED
   } phase_type;

   typedef struct packed {
      logic       is_start;
      logic       is_header;
      logic       is_file;
      logic       is_rx;
      logic       is_tick;
      logic       is_slot;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic [31:0] file_length;
      logic [15:0] wait_start_ticks;
      logic [15:0] wait_ack_ticks;
      logic [15:0] wait_close_ticks;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* rtl/ysf_front.sv */
module ysf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [2:0]        in_op,
   input  logic [7:0]        in_value,
   output logic              q_valid,
   output ysf_pkg::item_type q_item,
   input  logic              q_pop
);
   import ysf_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   decoded;
   logic       push;

   always_comb begin
      decoded = '0;
      decoded.value = in_value;
      unique case (in_op)
         OP_START:  decoded.is_start  = 1'b1;
         OP_HEADER: decoded.is_header = 1'b1;
         OP_FILE:   decoded.is_file   = 1'b1;
         OP_RX:     decoded.is_rx     = 1'b1;
         OP_TICK:   decoded.is_tick   = 1'b1;
         OP_SLOT:   decoded.is_slot   = 1'b1;
         default:   decoded.value     = in_value;  // unused codes carry no action
      endcase
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

/* rtl/ysf_back.sv */
module ysf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              q_valid,
   input  ysf_pkg::item_type q_item,
   output logic              q_pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_tx_valid,
   output logic [7:0]        out_tx_byte,
   output logic              out_frame_end,
   output logic              out_accepted,
   output logic [1:0]        out_status,
   output logic [31:0]       out_bytes_acked
);
   import ysf_pkg::*;

   logic [7:0] hdr_mem [SHORT_BLOCK_BYTES];
   logic [7:0] blk_mem [LONG_BLOCK_BYTES];
   logic [7:0] hdr_rdata_ff, blk_rdata_ff;

   cfg_type     cfg_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  hcount_ff, hcount_in;
   logic [10:0] fill_ff, fill_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  blknum_ff, blknum_in;
   logic        long_ff, long_in;
   logic [10:0] fpos_ff, fpos_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] timer_ff, timer_in;
   logic        ack_ff, ack_in;
   logic        eotp_ff, eotp_in;
   logic [31:0] total_ff, total_in;

   logic        fire, hdr_we, blk_we;
   logic        r_txv, r_last, r_acc;
   logic [7:0]  r_tx;
   logic [15:0] timer_sat, limit;
   logic        expired, waiting, is_data;
   logic [10:0] size, idx, fill_new;
   logic [31:0] target, sub, rem_new;
   logic [7:0]  num, db;
   logic [LONG_AW-1:0] raddr;

   function automatic logic [10:0] size_fill(input logic lng);
      return lng ? 11'(LONG_BLOCK_BYTES) : 11'(SHORT_BLOCK_BYTES);
   endfunction

   assign fire  = q_valid && (!out_valid || out_ready);
   assign q_pop = fire;

   always_comb begin
      phase_in = phase_ff;  hcount_in = hcount_ff; fill_in = fill_ff;
      remain_in = remain_ff; blknum_in = blknum_ff; long_in = long_ff;
      fpos_in = fpos_ff; crc_in = crc_ff; timer_in = timer_ff;
      ack_in = ack_ff; eotp_in = eotp_ff; total_in = total_ff;
      r_txv = 1'b0; r_last = 1'b0; r_acc = 1'b0; r_tx = 8'h00;
      hdr_we = 1'b0; blk_we = 1'b0;
      waiting = (phase_ff == PH_WAIT_START) || (phase_ff == PH_WAIT_HDR_ACK) ||
                (phase_ff == PH_WAIT_DATA_ACK) || (phase_ff == PH_WAIT_EOT_ACK) ||
                (phase_ff == PH_WAIT_CLOSE_ACK);
      timer_sat = (timer_ff == 16'hFFFF) ? timer_ff : timer_ff + 16'd1;
      priority case (phase_ff)
         PH_WAIT_START:                   limit = cfg_ff.wait_start_ticks;
         PH_WAIT_HDR_ACK, PH_WAIT_DATA_ACK: limit = cfg_ff.wait_ack_ticks;
         default:                         limit = cfg_ff.wait_close_ticks;
      endcase
      expired  = timer_sat >= limit;
      is_data  = (phase_ff == PH_SEND_DATA);
      size     = (is_data && long_ff) ? 11'(LONG_BLOCK_BYTES) : 11'(SHORT_BLOCK_BYTES);
      target   = (remain_ff < 32'(size_fill(long_ff))) ? remain_ff : 32'(size_fill(long_ff));
      fill_new = fill_ff + 11'd1;
      sub      = ({21'd0, fill_ff} < remain_ff) ? {21'd0, fill_ff} : remain_ff;
      rem_new  = remain_ff - sub;
      num      = is_data ? blknum_ff : 8'h00;
      idx      = fpos_ff - 11'd3;
      priority if (phase_ff == PH_SEND_HDR) begin
         db = (idx < {3'd0, hcount_ff}) ? hdr_rdata_ff : 8'h00;
      end else if (is_data) begin
         db = (idx < fill_ff) ? blk_rdata_ff : CH_PAD;
      end else begin
         db = 8'h00;
      end

      if (fire) begin
         priority if (q_item.is_start) begin
            if (phase_ff == PH_IDLE || phase_ff == PH_DONE || phase_ff == PH_FAILED) begin
               r_acc = 1'b1;
               hcount_in = 8'd0; fill_in = 11'd0; remain_in = cfg_ff.file_length;
               blknum_in = 8'd1; long_in = 1'b0; ack_in = 1'b0; eotp_in = 1'b0;
               total_in = 32'd0; phase_in = PH_WAIT_START; fpos_in = 11'd0;
               crc_in = 16'd0; timer_in = 16'd0;
            end
         end else if (q_item.is_header) begin
            if (phase_ff == PH_WAIT_START && !hcount_ff[7]) begin
               r_acc = 1'b1; hdr_we = 1'b1; hcount_in = hcount_ff + 8'd1;
            end
         end else if (q_item.is_file) begin
            if (phase_ff == PH_FILL && !fill_ff[10]) begin
               r_acc = 1'b1; blk_we = 1'b1; fill_in = fill_new;
               if ({21'd0, fill_new} >= target) begin
                  phase_in = PH_SEND_DATA; fpos_in = 11'd0; crc_in = 16'd0;
               end
            end
         end else if (q_item.is_rx || q_item.is_tick) begin
            if (waiting) begin
               r_acc = 1'b1;
               if (q_item.is_tick) timer_in = timer_sat;
               unique case (phase_ff)
                  PH_WAIT_START: begin
                     if (q_item.is_rx) begin
                        if (q_item.value == CH_C) begin
                           phase_in = PH_SEND_HDR; fpos_in = 11'd0; crc_in = 16'd0;
                        end
                     end else if (expired) phase_in = PH_FAILED;
                  end
                  PH_WAIT_HDR_ACK: begin
                     if (q_item.is_rx && q_item.value == CH_ACK) begin
                        ack_in = 1'b1;
                     end else if ((q_item.is_rx && ack_ff && q_item.value == CH_C) ||
                                  (q_item.is_tick && expired && ack_ff)) begin
                        if (remain_ff == 32'd0) phase_in = PH_SEND_EOT;
                        else begin
                           phase_in = PH_FILL; fill_in = 11'd0;
                           long_in = remain_ff > 32'(SHORT_BLOCK_BYTES);
                        end
                     end else if (q_item.is_tick && expired) phase_in = PH_FAILED;
                  end
                  PH_WAIT_DATA_ACK: begin
                     if (q_item.is_rx) begin
                        if (q_item.value == CH_ACK) begin
                           total_in = total_ff + {21'd0, fill_ff};
                           remain_in = rem_new;
                           blknum_in = blknum_ff + 8'd1;
                           if (rem_new == 32'd0) phase_in = PH_SEND_EOT;
                           else begin
                              phase_in = PH_FILL; fill_in = 11'd0;
                              long_in = rem_new > 32'(SHORT_BLOCK_BYTES);
                           end
                        end
                     end else if (expired) phase_in = PH_FAILED;
                  end
                  PH_WAIT_EOT_ACK: begin
                     if (q_item.is_rx) begin
                        if (q_item.value == CH_NAK) eotp_in = 1'b1;
                        else if (q_item.value == CH_ACK) begin
                           phase_in = PH_SEND_CLOSE; fpos_in = 11'd0; crc_in = 16'd0;
                        end
                     end else if (expired) begin
                        phase_in = PH_SEND_CLOSE; fpos_in = 11'd0; crc_in = 16'd0;
                     end
                  end
                  default: begin
                     if ((q_item.is_rx && q_item.value == CH_ACK) ||
                         (q_item.is_tick && expired)) phase_in = PH_DONE;
                  end
               endcase
            end
         end else if (q_item.is_slot) begin
            if (phase_ff == PH_SEND_HDR || is_data || phase_ff == PH_SEND_CLOSE) begin
               r_acc = 1'b1; r_txv = 1'b1;
               fpos_in = fpos_ff + 11'd1;
               priority if (fpos_ff == 11'd0) r_tx = (is_data && long_ff) ? CH_STX : CH_SOH;
               else if (fpos_ff == 11'd1) r_tx = num;
               else if (fpos_ff == 11'd2) r_tx = ~num;
               else if (fpos_ff < size + 11'd3) begin
                  r_tx = db; crc_in = crc_byte(crc_ff, db);
               end else if (fpos_ff == size + 11'd3) r_tx = crc_ff[15:8];
               else begin
                  r_tx = crc_ff[7:0]; r_last = 1'b1;
                  ack_in = 1'b0; timer_in = 16'd0;
                  priority if (phase_ff == PH_SEND_HDR) phase_in = PH_WAIT_HDR_ACK;
                  else if (is_data) phase_in = PH_WAIT_DATA_ACK;
                  else phase_in = PH_WAIT_CLOSE_ACK;
               end
            end else if (phase_ff == PH_SEND_EOT || (phase_ff == PH_WAIT_EOT_ACK && eotp_ff)) begin
               r_acc = 1'b1; r_txv = 1'b1; r_last = 1'b1; r_tx = CH_EOT; eotp_in = 1'b0;
               if (phase_ff == PH_SEND_EOT) begin
                  phase_in = PH_WAIT_EOT_ACK; timer_in = 16'd0;
               end
            end
         end
      end
      // read one position ahead so the registered data lines up with the next slot
      raddr = LONG_AW'(fpos_in - 11'd3);
   end

   always_ff @(posedge clock) begin
      if (hdr_we) hdr_mem[hcount_ff[SHORT_AW-1:0]] <= q_item.value;
      if (blk_we) blk_mem[fill_ff[LONG_AW-1:0]] <= q_item.value;
      hdr_rdata_ff <= hdr_mem[raddr[SHORT_AW-1:0]];
      blk_rdata_ff <= blk_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_length      <= 32'd0;
         cfg_ff.wait_start_ticks <= WAIT_START_RESET;
         cfg_ff.wait_ack_ticks   <= WAIT_ACK_RESET;
         cfg_ff.wait_close_ticks <= WAIT_CLOSE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FILE_LENGTH: cfg_ff.file_length      <= csr_data;
            CSR_WAIT_START:  cfg_ff.wait_start_ticks <= csr_data[15:0];
            CSR_WAIT_ACK:    cfg_ff.wait_ack_ticks   <= csr_data[15:0];
            CSR_WAIT_CLOSE:  cfg_ff.wait_close_ticks <= csr_data[15:0];
            default:         cfg_ff.file_length      <= cfg_ff.file_length;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; hcount_ff <= 8'd0; fill_ff <= 11'd0; remain_ff <= 32'd0;
         blknum_ff <= 8'd1; long_ff <= 1'b0; fpos_ff <= 11'd0; crc_ff <= 16'd0;
         timer_ff <= 16'd0; ack_ff <= 1'b0; eotp_ff <= 1'b0; total_ff <= 32'd0;
         out_valid <= 1'b0;
      end else begin
         phase_ff <= phase_in; hcount_ff <= hcount_in; fill_ff <= fill_in;
         remain_ff <= remain_in; blknum_ff <= blknum_in; long_ff <= long_in;
         fpos_ff <= fpos_in; crc_ff <= crc_in; timer_ff <= timer_in;
         ack_ff <= ack_in; eotp_ff <= eotp_in; total_ff <= total_in;
         if (fire) out_valid <= 1'b1;
         else if (out_ready) out_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_tx_valid    <= r_txv;
         out_tx_byte     <= r_tx;
         out_frame_end   <= r_last;
         out_accepted    <= r_acc;
         out_bytes_acked <= total_in;
         priority case (phase_in)
            PH_IDLE:   out_status <= ST_IDLE;
            PH_DONE:   out_status <= ST_DONE;
            PH_FAILED: out_status <= ST_FAILED;
            default:   out_status <= ST_BUSY;
         endcase
      end
   end
endmodule

/* rtl/ymodem_sender_framer.sv */
// channel  dir  handshake                 payload
// req      in   req_tvalid/req_tready     tuser op, tdata byte_value
// rsp      out  rsp_tvalid/rsp_tready     tuser tx_valid, tlast frame_end, tdata rest
// csr      in   csr_valid/csr_ready       csr_index, csr_data
// one item a cycle sustained while rsp does not stall; a taken req beat sits in a
// two-beat queue, then the back state machine processes it into registers offered on rsp
// block bytes come from registered memory reads issued one position ahead
// synchronous reset clears control state and sets csr defaults; stores are not cleared
// rsp stalls fill the queue, then req_tready drops
module ymodem_sender_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] tx_byte, [8] accepted, [10:9] status,
                                    // [42:11] bytes_acked, rest zero
   output logic        rsp_tuser,   // [0] tx_valid
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ysf_pkg::*;

   logic        q_valid, q_pop;
   item_type    q_item;
   logic [7:0]  tx_byte;
   logic        accepted;
   logic [1:0]  status;
   logic [31:0] bytes_acked;

   assign csr_ready = 1'b1;

   ysf_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tuser), .in_value(req_tdata),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   ysf_back u_back (
      .clock(clock), .reset(reset),
      .csr_write(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_tx_valid(rsp_tuser), .out_tx_byte(tx_byte), .out_frame_end(rsp_tlast),
      .out_accepted(accepted), .out_status(status), .out_bytes_acked(bytes_acked)
   );

   assign rsp_tdata = {5'd0, bytes_acked, status, accepted, tx_byte};

   a_tx_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[8]) else $error("sent byte not accepted");
   a_last_sent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser) else $error("frame end without byte");
   a_idle_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00) else $error("stray byte");
   a_reset_out: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result after reset");
endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ysf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [2:0] op;
      logic [7:0] value;
   } req_beat_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        frame_end;
      logic        accepted;
      logic [1:0]  status;
      logic [31:0] bytes_acked;
   } reply_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   ymodem_sender_framer dut (.*);

   req_beat_type pending_beats[$];
   reply_type    expected_replies[$];
   int           mismatches = 0;
   int           cycles = 0;

   // shadow of the framer
   logic [31:0] sh_file_length;
   logic [15:0] sh_wait_start, sh_wait_ack, sh_wait_close;
   phase_type   sh_phase;
   logic [7:0]  sh_hdr[SHORT_BLOCK_BYTES];
   int          sh_hdr_cnt;
   logic [7:0]  sh_blk[LONG_BLOCK_BYTES];
   int          sh_fill_cnt;
   logic [31:0] sh_remaining;
   logic [7:0]  sh_blk_num;
   logic        sh_long;
   int          sh_fpos;
   logic [15:0] sh_crc;
   int          sh_timer;
   logic        sh_ack_seen, sh_eot_pend;
   logic [31:0] sh_acked;

   function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] d);
      c = c ^ {d, 8'h00};
      for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic void begin_wait(phase_type nxt);
      sh_phase = nxt;
      sh_timer = 0;
   endfunction

   function automatic void begin_frame(phase_type nxt);
      sh_phase = nxt;
      sh_fpos = 0;
      sh_crc = '0;
   endfunction

   function automatic void begin_fill();
      sh_phase = PH_FILL;
      sh_fill_cnt = 0;
      sh_long = sh_remaining > SHORT_BLOCK_BYTES;
   endfunction

   function automatic logic [31:0] fill_goal();
      logic [31:0] size;
      size = sh_long ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
      return (sh_remaining < size) ? sh_remaining : size;
   endfunction

   function automatic logic tick_over(logic [15:0] lim);
      if (sh_timer < 65535) sh_timer++;
      return sh_timer >= lim;
   endfunction

   function automatic logic [7:0] frame_octet(output logic last);
      logic        data;
      int          size, i;
      logic [7:0]  num, b;
      data = (sh_phase == PH_SEND_DATA);
      size = (data && sh_long) ? LONG_BLOCK_BYTES : SHORT_BLOCK_BYTES;
      num = data ? sh_blk_num : 8'h00;
      last = 1'b0;
      if (sh_fpos == 0) b = (data && sh_long) ? CH_STX : CH_SOH;
      else if (sh_fpos == 1) b = num;
      else if (sh_fpos == 2) b = 8'hFF - num;
      else if (sh_fpos < 3 + size) begin
         i = sh_fpos - 3;
         if (sh_phase == PH_SEND_HDR) b = (i < sh_hdr_cnt) ? sh_hdr[i] : 8'h00;
         else if (data) b = (i < sh_fill_cnt) ? sh_blk[i] : CH_PAD;
         else b = 8'h00;
         sh_crc = crc16_update(sh_crc, b);
      end else if (sh_fpos == 3 + size) b = sh_crc[15:8];
      else begin
         b = sh_crc[7:0];
         last = 1'b1;
      end
      sh_fpos = (sh_fpos + 1) & 11'h7FF;
      return b;
   endfunction

   function automatic reply_type framer_step(logic [2:0] op, logic [7:0] b);
      reply_type r;
      logic   waiting, last, used;
      logic   [31:0] take;
      r = '0;
      used = 1'b0;
      waiting = sh_phase inside {PH_WAIT_START, PH_WAIT_HDR_ACK, PH_WAIT_DATA_ACK,
                                 PH_WAIT_EOT_ACK, PH_WAIT_CLOSE_ACK};
      case (op)
         OP_START: begin
            if (sh_phase inside {PH_IDLE, PH_DONE, PH_FAILED}) begin
               used = 1'b1;
               sh_hdr_cnt = 0;
               sh_fill_cnt = 0;
               sh_remaining = sh_file_length;
               sh_blk_num = 8'd1;
               sh_long = 1'b0;
               sh_ack_seen = 1'b0;
               sh_eot_pend = 1'b0;
               sh_acked = '0;
               begin_frame(PH_WAIT_START);
               sh_timer = 0;
            end
         end
         OP_HEADER: begin
            if (sh_phase == PH_WAIT_START && sh_hdr_cnt < SHORT_BLOCK_BYTES) begin
               used = 1'b1;
               sh_hdr[sh_hdr_cnt] = b;
               sh_hdr_cnt++;
            end
         end
         OP_FILE: begin
            if (sh_phase == PH_FILL && sh_fill_cnt < LONG_BLOCK_BYTES) begin
               used = 1'b1;
               sh_blk[sh_fill_cnt] = b;
               sh_fill_cnt++;
               if (sh_fill_cnt >= fill_goal()) begin_frame(PH_SEND_DATA);
            end
         end
         OP_RX: begin
            if (waiting) begin
               used = 1'b1;
               case (sh_phase)
                  PH_WAIT_START: if (b == CH_C) begin_frame(PH_SEND_HDR);
                  PH_WAIT_HDR_ACK: begin
                     if (b == CH_ACK) sh_ack_seen = 1'b1;
                     else if (sh_ack_seen && b == CH_C) begin
                        if (sh_remaining == 0) sh_phase = PH_SEND_EOT;
                        else begin_fill();
                     end
                  end
                  PH_WAIT_DATA_ACK: begin
                     if (b == CH_ACK) begin
                        sh_acked += sh_fill_cnt;
                        take = sh_fill_cnt;
                        sh_remaining -= (take < sh_remaining) ? take : sh_remaining;
                        sh_blk_num++;
                        if (sh_remaining == 0) sh_phase = PH_SEND_EOT;
                        else begin_fill();
                     end
                  end
                  PH_WAIT_EOT_ACK: begin
                     if (b == CH_NAK) sh_eot_pend = 1'b1;
                     else if (b == CH_ACK) begin_frame(PH_SEND_CLOSE);
                  end
                  default: if (b == CH_ACK) sh_phase = PH_DONE;
               endcase
            end
         end
         OP_TICK: begin
            if (waiting) begin
               used = 1'b1;
               case (sh_phase)
                  PH_WAIT_START: if (tick_over(sh_wait_start)) sh_phase = PH_FAILED;
                  PH_WAIT_HDR_ACK: begin
                     if (tick_over(sh_wait_ack)) begin
                        if (!sh_ack_seen) sh_phase = PH_FAILED;
                        else if (sh_remaining == 0) sh_phase = PH_SEND_EOT;
                        else begin_fill();
                     end
                  end
                  PH_WAIT_DATA_ACK: if (tick_over(sh_wait_ack)) sh_phase = PH_FAILED;
                  PH_WAIT_EOT_ACK: if (tick_over(sh_wait_close)) begin_frame(PH_SEND_CLOSE);
                  default: if (tick_over(sh_wait_close)) sh_phase = PH_DONE;
               endcase
            end
         end
         OP_SLOT: begin
            if (sh_phase inside {PH_SEND_HDR, PH_SEND_DATA, PH_SEND_CLOSE}) begin
               used = 1'b1;
               r.tx_valid = 1'b1;
               r.tx_byte = frame_octet(last);
               r.frame_end = last;
               if (last) begin
                  sh_ack_seen = 1'b0;
                  case (sh_phase)
                     PH_SEND_HDR:  begin_wait(PH_WAIT_HDR_ACK);
                     PH_SEND_DATA: begin_wait(PH_WAIT_DATA_ACK);
                     default:      begin_wait(PH_WAIT_CLOSE_ACK);
                  endcase
               end
            end else if (sh_phase == PH_SEND_EOT || (sh_phase == PH_WAIT_EOT_ACK && sh_eot_pend))
            begin
               used = 1'b1;
               r.tx_valid = 1'b1;
               r.frame_end = 1'b1;
               r.tx_byte = CH_EOT;
               sh_eot_pend = 1'b0;
               if (sh_phase == PH_SEND_EOT) begin_wait(PH_WAIT_EOT_ACK);
            end
         end
         default: ;
      endcase
      r.accepted = used;
      r.status = (sh_phase == PH_IDLE) ? ST_IDLE : (sh_phase == PH_DONE) ? ST_DONE :
                 (sh_phase == PH_FAILED) ? ST_FAILED : ST_BUSY;
      r.bytes_acked = sh_acked;
      return r;
   endfunction

   task automatic queue_item(logic [2:0] op, logic [7:0] b);
      req_beat_type it;
      it.op = op;
      it.value = b;
      pending_beats.insert(pending_beats.size(), it);
      expected_replies.insert(expected_replies.size(), framer_step(op, b));
   endtask

   // mostly the protocol's next move, sometimes noise
   task automatic pick_item(int hdr_goal, output logic [2:0] op, output logic [7:0] b);
      int roll;
      roll = $urandom_range(0, 99);
      b = 8'($urandom_range(0, 255));
      if (roll < 6) begin
         op = 3'($urandom_range(0, 7));
         return;
      end
      if (roll < 12 && sh_phase inside {PH_WAIT_START, PH_WAIT_HDR_ACK, PH_WAIT_DATA_ACK,
                                        PH_WAIT_EOT_ACK, PH_WAIT_CLOSE_ACK}) begin
         op = OP_TICK;
         return;
      end
      case (sh_phase)
         PH_IDLE, PH_DONE, PH_FAILED: op = OP_START;
         PH_WAIT_START: begin
            if (sh_hdr_cnt < hdr_goal) op = OP_HEADER;
            else begin
               op = OP_RX;
               b = CH_C;
            end
         end
         PH_SEND_HDR, PH_SEND_DATA, PH_SEND_CLOSE, PH_SEND_EOT: op = OP_SLOT;
         PH_WAIT_HDR_ACK: begin
            op = OP_RX;
            if (roll > 95) b = 8'($urandom_range(0, 255));
            else b = sh_ack_seen ? CH_C : CH_ACK;
         end
         PH_FILL: op = OP_FILE;
         PH_WAIT_DATA_ACK: begin
            op = OP_RX;
            b = (roll < 85) ? CH_ACK : (roll < 92 ? CH_NAK : b);
         end
         PH_WAIT_EOT_ACK: begin
            if (sh_eot_pend) op = OP_SLOT;
            else begin
               op = OP_RX;
               b = (roll < 45) ? CH_NAK : CH_ACK;
            end
         end
         default: begin
            op = OP_RX;
            b = CH_ACK;
         end
      endcase
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_FILE_LENGTH: sh_file_length = val;
         CSR_WAIT_START:  sh_wait_start = val[15:0];
         CSR_WAIT_ACK:    sh_wait_ack = val[15:0];
         default:         sh_wait_close = val[15:0];
      endcase
   endtask

   function automatic logic [15:0] pick_wait(int round);
      if (round == 1) return 16'd0;
      if (round == 2) return 16'hFFFF;
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 4));
         1: return 16'($urandom_range(5, 60));
         default: return 16'($urandom_range(200, 65535));
      endcase
   endfunction

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // driver
   int req_gap = 0;
   int req_quiet = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            void'(pending_beats.pop_front());
            if (req_quiet > 0) req_quiet--;
            else if ($urandom_range(0, 60) == 0) req_quiet = $urandom_range(20, 80);
            req_gap = (req_quiet > 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 14);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_beats[0].value;
            req_tuser <= pending_beats[0].op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   int rsp_stall = 0;
   int rsp_quiet = 0;
   always @(posedge clock) begin
      reply_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.tx_valid = rsp_tuser;
            got.tx_byte = rsp_tdata[7:0];
            got.frame_end = rsp_tlast;
            got.accepted = rsp_tdata[8];
            got.status = rsp_tdata[10:9];
            got.bytes_acked = rsp_tdata[42:11];
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %p", got);
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, got);
               end
            end
            if (rsp_quiet > 0) rsp_quiet--;
            else if ($urandom_range(0, 60) == 0) rsp_quiet = $urandom_range(20, 80);
            rsp_stall = (rsp_quiet > 0 || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 14);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic drain();
      while (pending_beats.size() > 0 || expected_replies.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int          total, n, round, hdr_goal, cap;
      logic [2:0]  op;
      logic [7:0]  b;
      logic [31:0] flen;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sh_file_length = '0;
      sh_wait_start = WAIT_START_RESET;
      sh_wait_ack = WAIT_ACK_RESET;
      sh_wait_close = WAIT_CLOSE_RESET;
      sh_phase = PH_IDLE;
      sh_hdr_cnt = 0;
      sh_fill_cnt = 0;
      sh_remaining = '0;
      sh_blk_num = 8'd1;
      sh_long = 1'b0;
      sh_fpos = 0;
      sh_crc = '0;
      sh_timer = 0;
      sh_ack_seen = 1'b0;
      sh_eot_pend = 1'b0;
      sh_acked = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: everything while idle, then an empty-file session opening
      queue_item(3'd6, 8'hAA);
      queue_item(3'd7, 8'h55);
      queue_item(OP_SLOT, 8'h00);
      queue_item(OP_TICK, 8'hFF);
      queue_item(OP_HEADER, 8'h00);
      queue_item(OP_FILE, 8'hFF);
      queue_item(OP_RX, CH_C);
      queue_item(OP_START, 8'h00);
      queue_item(OP_START, 8'hFF);
      queue_item(OP_HEADER, 8'h00);
      queue_item(OP_HEADER, 8'hFF);
      queue_item(OP_FILE, 8'h12);
      queue_item(OP_RX, CH_NAK);
      queue_item(OP_TICK, 8'h00);
      queue_item(OP_SLOT, 8'h00);
      queue_item(OP_RX, CH_C);
      queue_item(OP_RX, CH_C);
      queue_item(OP_TICK, 8'h00);
      drain();

      total = 0;
      round = 0;
      while (total < 1350) begin
         round++;
         cap = 1350 - total;
         case (round)
            1: flen = 0;
            2: flen = 128;
            3: flen = 129;
            default: flen = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2)
                                                      : $urandom_range(1, 260);
         endcase
         if (cap <= 300) flen = 32'hFFFF_FFFF;
         csr_write(CSR_FILE_LENGTH, flen);
         csr_write(CSR_WAIT_START, pick_wait(round));
         csr_write(CSR_WAIT_ACK, pick_wait(round));
         csr_write(CSR_WAIT_CLOSE, pick_wait(round));
         hdr_goal = $urandom_range(0, 3) == 0 ? $urandom_range(129, 140) : $urandom_range(0, 40);
         n = 0;
         do begin
            pick_item(hdr_goal, op, b);
            queue_item(op, b);
            n++;
         end while (n < cap && !(n > 3 && sh_phase inside {PH_DONE, PH_FAILED}));
         total += n;
         drain();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
